// ===== rtl/core/utf8d_pkg.sv =====
package utf8d_pkg;

    // Default number of classified bytes held between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int INDEX_W = 32;
    localparam int LEN_W   = 3;

    // Lead byte patterns of the original UTF-8 form.
    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'he0;
    localparam logic [7:0] LEAD2_CODE = 8'hc0;
    localparam logic [7:0] LEAD3_MASK = 8'hf0;
    localparam logic [7:0] LEAD3_CODE = 8'he0;
    localparam logic [7:0] LEAD4_MASK = 8'hf8;
    localparam logic [7:0] LEAD4_CODE = 8'hf0;
    localparam logic [7:0] LEAD5_MASK = 8'hfc;
    localparam logic [7:0] LEAD5_CODE = 8'hf8;
    localparam logic [7:0] LEAD6_MASK = 8'hfe;
    localparam logic [7:0] LEAD6_CODE = 8'hfc;

    localparam logic [5:0] CONT_BITS = 6'h3f;

    // Class of one text byte.
    typedef enum logic [1:0] {
        BK_CONT   = 2'd0,
        BK_SINGLE = 2'd1,
        BK_LEAD   = 2'd2
    } byte_kind_t;

    // One classified byte as it travels from front to back.
    typedef struct packed {
        byte_kind_t        kind;
        logic [LEN_W-1:0]  seq_len;
        logic [BYTE_W-1:0] data;
        logic              eot;
    } entry_t;

    // Classify a byte; lead bytes come back with their marker bits cleared.
    function automatic entry_t classify(input logic [BYTE_W-1:0] b, input logic eot);
        entry_t e;
        e.eot  = eot;
        e.data = b;
        e.kind = BK_LEAD;
        if ((b & CONT_MASK) == CONT_CODE) begin
            e.kind    = BK_CONT;
            e.seq_len = 3'd0;
            e.data    = b & {2'b00, CONT_BITS};
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            e.seq_len = 3'd2;
            e.data    = b & ~LEAD2_MASK;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            e.seq_len = 3'd3;
            e.data    = b & ~LEAD3_MASK;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            e.seq_len = 3'd4;
            e.data    = b & ~LEAD4_MASK;
        end else if ((b & LEAD5_MASK) == LEAD5_CODE) begin
            e.seq_len = 3'd5;
            e.data    = b & ~LEAD5_MASK;
        end else if ((b & LEAD6_MASK) == LEAD6_CODE) begin
            e.seq_len = 3'd6;
            e.data    = b & ~LEAD6_MASK;
        end else begin
            e.kind    = BK_SINGLE;
            e.seq_len = 3'd1;
        end
        return e;
    endfunction

endpackage

// ===== rtl/core/utf8_code_point_decoder.sv =====
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+---------------------------------------------
// s_        | in        | s_valid / s_ready  | s_text_byte[7:0], s_end_of_text
// m_        | out       | m_valid / m_ready  | m_code_point[30:0], m_char_index[31:0],
//           |           |                    | m_seq_bytes[2:0], m_dropped_partial
//
// One byte per clock is sustained while m_ready is high.
// An accepted byte passes through the queue before any result it completes is registered.
// The classify front and decode back are parted by a queue of QUEUE_DEPTH entries.
// Reset (aresetn, synchronous, active low) empties the queue and clears decoder state.
// A stalled result channel fills the queue; s_ready drops only when it is full.
module utf8_code_point_decoder #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]     s_text_byte,
    input  logic                             s_end_of_text,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [utf8d_pkg::CP_W-1:0]       m_code_point,
    output logic [utf8d_pkg::INDEX_W-1:0]    m_char_index,
    output logic [utf8d_pkg::LEN_W-1:0]      m_seq_bytes,
    output logic                             m_dropped_partial
);
    import utf8d_pkg::*;

    logic   push, queue_full, pop, queue_valid;
    entry_t push_entry, head_entry;

    utf8d_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .push          (push),
        .push_entry    (push_entry),
        .queue_full    (queue_full)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_valid),
        .head_entry (head_entry)
    );

    utf8d_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .entry_valid       (queue_valid),
        .entry             (head_entry),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_code_point      (m_code_point),
        .m_char_index      (m_char_index),
        .m_seq_bytes       (m_seq_bytes),
        .m_dropped_partial (m_dropped_partial)
    );

endmodule

// ===== rtl/core/utf8d_front.sv =====
module utf8d_front (
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]    s_text_byte,
    input  logic                            s_end_of_text,
    output logic                            push,
    output utf8d_pkg::entry_t               push_entry,
    input  logic                            queue_full
);
    import utf8d_pkg::*;

    // A byte is taken whenever the queue has room.
    assign s_ready    = !queue_full;
    assign push       = s_valid && !queue_full;
    assign push_entry = classify(s_text_byte, s_end_of_text);

endmodule

// ===== rtl/core/utf8d_queue.sv =====
module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  utf8d_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output utf8d_pkg::entry_t head_entry
);
    import utf8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    entry_t           slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign not_empty  = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && not_empty;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/utf8d_back.sv =====
module utf8d_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             entry_valid,
    input  utf8d_pkg::entry_t                entry,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [utf8d_pkg::CP_W-1:0]       m_code_point,
    output logic [utf8d_pkg::INDEX_W-1:0]    m_char_index,
    output logic [utf8d_pkg::LEN_W-1:0]      m_seq_bytes,
    output logic                             m_dropped_partial
);
    import utf8d_pkg::*;

    // Decoder state.
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic [LEN_W-1:0]   total_reg, total_next;
    logic [CP_W-1:0]    partial_reg, partial_next;
    logic [INDEX_W-1:0] counter_reg, counter_next;
    logic               drop_reg, drop_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [CP_W-1:0]    out_cp_reg, out_cp_next;
    logic [INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [LEN_W-1:0]   out_len_reg, out_len_next;
    logic               out_drop_reg, out_drop_next;

    logic               take;
    logic               emit;
    logic [CP_W-1:0]    shifted;

    // An entry is consumed when the output register is free or being drained.
    assign take    = entry_valid && (!out_valid_reg || m_ready);
    assign pop     = take;
    assign shifted = {partial_reg[CP_W-7:0], entry.data[5:0]};

    always_comb begin
        remain_next   = remain_reg;
        total_next    = total_reg;
        partial_next  = partial_reg;
        counter_next  = counter_reg;
        drop_next     = drop_reg;
        emit          = 1'b0;
        out_cp_next   = out_cp_reg;
        out_idx_next  = out_idx_reg;
        out_len_next  = out_len_reg;
        out_drop_next = out_drop_reg;

        if (take) begin
            case (entry.kind)
                BK_CONT: begin
                    // Continuation shifts in six bits; stray ones are ignored.
                    if (remain_reg != '0) begin
                        partial_next = shifted;
                        remain_next  = remain_reg - 1'b1;
                        if (remain_reg == LEN_W'(1)) begin
                            emit          = 1'b1;
                            out_cp_next   = shifted;
                            out_idx_next  = counter_reg - 1'b1;
                            out_len_next  = total_reg;
                            out_drop_next = drop_reg;
                            drop_next     = 1'b0;
                            total_next    = '0;
                        end
                    end
                end
                BK_SINGLE: begin
                    // Single-byte character completes at once.
                    emit          = 1'b1;
                    out_cp_next   = CP_W'(entry.data);
                    out_idx_next  = counter_reg;
                    out_len_next  = LEN_W'(1);
                    out_drop_next = (remain_reg != '0);
                    counter_next  = counter_reg + 1'b1;
                    remain_next   = '0;
                    total_next    = '0;
                    partial_next  = '0;
                    drop_next     = 1'b0;
                end
                BK_LEAD: begin
                    // Lead byte opens a new sequence, abandoning any open one.
                    drop_next    = (remain_reg != '0);
                    partial_next = CP_W'(entry.data);
                    remain_next  = entry.seq_len - 1'b1;
                    total_next   = entry.seq_len;
                    counter_next = counter_reg + 1'b1;
                end
                default: begin
                    remain_next = remain_reg;
                end
            endcase

            // End of text clears the decoder state after the result is formed.
            if (entry.eot) begin
                remain_next  = '0;
                total_next   = '0;
                partial_next = '0;
                drop_next    = 1'b0;
                counter_next = '0;
            end
        end

        // Output valid follows the handshake and new results.
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remain_reg    <= '0;
            total_reg     <= '0;
            partial_reg   <= '0;
            counter_reg   <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            partial_reg   <= partial_next;
            counter_reg   <= counter_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload loads only with a new result.
    always_ff @(posedge aclk) begin
        if (emit) begin
            out_cp_reg   <= out_cp_next;
            out_idx_reg  <= out_idx_next;
            out_len_reg  <= out_len_next;
            out_drop_reg <= out_drop_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_code_point      = out_cp_reg;
    assign m_char_index      = out_idx_reg;
    assign m_seq_bytes       = out_len_reg;
    assign m_dropped_partial = out_drop_reg;

endmodule
